/* hw/rtl/smfd_pkg.sv */
// shared constants, queue item type and helpers for the fraction divider
package smfd_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRACTION_BITS = 5;
  localparam int WHOLE_WIDTH   = DATA_WIDTH - 1;
  localparam int STEPS         = DATA_WIDTH + FRACTION_BITS;
  localparam int CNT_WIDTH     = $clog2(STEPS);
  // queue depth, power of two
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_WIDTH    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] mag_t;

  typedef struct packed {
    mag_t dividend_mag;
    mag_t divisor_mag;
    logic negative;
    logic div_by_zero;
  } job_t;

  // magnitude of a two's complement word, exact for the most negative value
  function automatic mag_t magnitude(input logic [DATA_WIDTH-1:0] x);
    mag_t m;
    m = x[DATA_WIDTH-1] ? (~x + mag_t'(1)) : x;
    return m;
  endfunction

endpackage

/* hw/rtl/smfd_front.sv */
// front stage: takes operands, forms magnitudes and classifies the item
module smfd_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [smfd_pkg::DATA_WIDTH-1:0] in_dividend,
  input  logic [smfd_pkg::DATA_WIDTH-1:0] in_divisor,
  output logic                            push_valid,
  input  logic                            push_ready,
  output smfd_pkg::job_t                  push_job
);

  logic           valid_r;
  logic           valid_nxt;
  smfd_pkg::job_t job_r;
  smfd_pkg::job_t job_nxt;
  logic           accept;
  logic           a_zero;
  logic           d_zero;

  assign in_stall = valid_r && !push_ready;
  assign accept   = in_valid && !in_stall;
  assign a_zero   = (in_dividend == '0);
  assign d_zero   = (in_divisor == '0);

  always_comb begin
    job_nxt              = job_r;
    job_nxt.dividend_mag = smfd_pkg::magnitude(in_dividend);
    job_nxt.divisor_mag  = smfd_pkg::magnitude(in_divisor);
    job_nxt.div_by_zero  = d_zero;
    // sign only matters for a real, nonzero quotient
    job_nxt.negative     = !a_zero && !d_zero &&
                           (in_dividend[smfd_pkg::DATA_WIDTH-1] ^
                            in_divisor[smfd_pkg::DATA_WIDTH-1]);
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_job   = job_r;

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !push_ready) |=> (valid_r && $stable(job_r)))
    else $error("front item changed while queue full");

  a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (accept) |=> valid_r)
    else $error("accepted item not held in front register");

  a_front_dbz: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && job_r.div_by_zero) |-> !job_r.negative)
    else $error("divide by zero item marked negative");

endmodule

/* hw/rtl/smfd_queue.sv */
// short queue between the front stage and the divider core
module smfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  smfd_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output smfd_pkg::job_t pop_job
);

  smfd_pkg::job_t                        slot_r [smfd_pkg::QUEUE_DEPTH];
  logic [smfd_pkg::QPTR_WIDTH-1:0]       wr_ptr_r;
  logic [smfd_pkg::QPTR_WIDTH-1:0]       rd_ptr_r;
  logic [smfd_pkg::QCNT_WIDTH-1:0]       count_r;
  logic                                  push;
  logic                                  pop;

  assign push_ready = (count_r != smfd_pkg::QCNT_WIDTH'(smfd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= smfd_pkg::QCNT_WIDTH'(smfd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_queue_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue pop lost");

endmodule

/* hw/rtl/smfd_core.sv */
// divider core: restoring shift-and-subtract, one quotient bit per cycle
module smfd_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  smfd_pkg::job_t                    pop_job,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [smfd_pkg::WHOLE_WIDTH-1:0]  out_quotient_whole,
  output logic [smfd_pkg::FRACTION_BITS-1:0] out_quotient_fraction,
  output logic                              out_negative,
  output logic                              out_div_by_zero
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_OUT
  } state_t;

  state_t                              state_r;
  logic [smfd_pkg::DATA_WIDTH-1:0]     a_r;
  logic [smfd_pkg::DATA_WIDTH-1:0]     d_r;
  logic [smfd_pkg::DATA_WIDTH-1:0]     rem_r;
  logic [smfd_pkg::DATA_WIDTH-1:0]     rem_nxt;
  logic [smfd_pkg::STEPS-1:0]          q_r;
  logic [smfd_pkg::STEPS-1:0]          q_nxt;
  logic [smfd_pkg::CNT_WIDTH-1:0]      cnt_r;
  logic                                neg_r;
  logic [smfd_pkg::DATA_WIDTH:0]       rem_sh;
  logic [smfd_pkg::DATA_WIDTH:0]       diff;
  logic                                take;
  logic [smfd_pkg::DATA_WIDTH-1:0]     whole_full;
  logic                                out_valid_r;
  logic [smfd_pkg::WHOLE_WIDTH-1:0]    whole_r;
  logic [smfd_pkg::FRACTION_BITS-1:0]  frac_r;
  logic                                negative_r;
  logic                                dbz_r;

  // once the dividend bits run out, zeros shift in for the fraction bits
  assign rem_sh     = {rem_r, a_r[smfd_pkg::DATA_WIDTH-1]};
  assign diff       = rem_sh - {1'b0, d_r};
  assign take       = !diff[smfd_pkg::DATA_WIDTH];
  assign rem_nxt    = take ? diff[smfd_pkg::DATA_WIDTH-1:0]
                           : rem_sh[smfd_pkg::DATA_WIDTH-1:0];
  assign q_nxt      = {q_r[smfd_pkg::STEPS-2:0], take};
  assign whole_full = q_nxt[smfd_pkg::STEPS-1:smfd_pkg::FRACTION_BITS];
  assign pop_ready  = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            a_r   <= pop_job.dividend_mag;
            d_r   <= pop_job.divisor_mag;
            neg_r <= pop_job.negative;
            rem_r <= '0;
            q_r   <= '0;
            cnt_r <= smfd_pkg::CNT_WIDTH'(smfd_pkg::STEPS - 1);
            if (pop_job.div_by_zero) begin
              whole_r     <= '0;
              frac_r      <= '0;
              negative_r  <= 1'b0;
              dbz_r       <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          a_r   <= {a_r[smfd_pkg::DATA_WIDTH-2:0], 1'b0};
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            // quotient of 2^(w-1) by one does not fit: saturate
            if (whole_full[smfd_pkg::DATA_WIDTH-1]) begin
              whole_r <= '1;
              frac_r  <= '1;
            end else begin
              whole_r <= whole_full[smfd_pkg::WHOLE_WIDTH-1:0];
              frac_r  <= q_nxt[smfd_pkg::FRACTION_BITS-1:0];
            end
            negative_r  <= neg_r;
            dbz_r       <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_quotient_whole    = whole_r;
  assign out_quotient_fraction = frac_r;
  assign out_negative          = negative_r;
  assign out_div_by_zero       = dbz_r;

  a_core_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == (state_r == S_OUT))
    else $error("result valid out of step with state");

  a_core_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && cnt_r == '0) |=> (out_valid_r && !dbz_r))
    else $error("last step did not present a result");

  a_core_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dbz_r) |-> (whole_r == '0 && frac_r == '0 && !negative_r))
    else $error("divide by zero result not cleared");

  a_core_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (rem_r < d_r))
    else $error("partial remainder not below divisor");

endmodule

/* hw/rtl/sign_magnitude_fraction_divider_top.sv */
// top level of the sign-magnitude fraction divider
// Usage: the input channel (in_valid, in_stall, in_dividend, in_divisor) takes
// two signed two's complement operands; an item is taken on a clock edge with
// in_valid high and in_stall low. The result channel (out_valid, out_stall)
// returns the magnitude quotient as a 31-bit whole part and 5 truncated
// fraction bits, a negative flag and a div_by_zero flag, one result per item,
// in order. A zero divisor gives div_by_zero with all other fields zero.
// An item taken passes the front register and the queue, is loaded into the
// core and then takes 37 restoring steps (one per quotient bit: 32 whole
// bits plus 5 fraction bits) in the single subtractor, the last of which writes
// the result register. The core takes no new item until its result is taken,
// so the subtract loop sets the throughput; a zero divisor skips it.
// The front and a two-entry queue keep taking items while the core works.
// When out_stall is high the result holds and the core waits; the queue
// then fills and in_stall rises. Synchronous active-low reset empties the
// front register and queue and returns the core to idle, dropping any item.
module sign_magnitude_fraction_divider_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [smfd_pkg::DATA_WIDTH-1:0]    in_dividend,
  input  logic [smfd_pkg::DATA_WIDTH-1:0]    in_divisor,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [smfd_pkg::WHOLE_WIDTH-1:0]   out_quotient_whole,
  output logic [smfd_pkg::FRACTION_BITS-1:0] out_quotient_fraction,
  output logic                               out_negative,
  output logic                               out_div_by_zero
);

  logic           push_valid;
  logic           push_ready;
  smfd_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  smfd_pkg::job_t pop_job;

  smfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  smfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  smfd_core u_core (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .pop_valid             (pop_valid),
    .pop_ready             (pop_ready),
    .pop_job               (pop_job),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_quotient_whole    (out_quotient_whole),
    .out_quotient_fraction (out_quotient_fraction),
    .out_negative          (out_negative),
    .out_div_by_zero       (out_div_by_zero)
  );

endmodule

/* bench/sign_magnitude_fraction_divider_top_tb.sv */
// self-checking testbench for the sign-magnitude fraction divider
module sign_magnitude_fraction_divider_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = smfd_pkg::DATA_WIDTH;
  localparam int WW = smfd_pkg::WHOLE_WIDTH;
  localparam int FB = smfd_pkg::FRACTION_BITS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    logic [WW-1:0] whole;
    logic [FB-1:0] fraction;
    logic          negative;
    logic          div_by_zero;
  } quotient_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [DW-1:0] in_dividend = '0;
  logic [DW-1:0] in_divisor = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [WW-1:0] out_quotient_whole;
  logic [FB-1:0] out_quotient_fraction;
  logic          out_negative;
  logic          out_div_by_zero;

  quotient_t expected_quotients[$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        cycle_count = 0;
  int        zero_divisor_count = 0;
  bit        send_gaps_on = 1'b0;
  bit        recv_gaps_on = 1'b0;
  int        hold_req = 0;
  int        hold_left = 0;
  int        burst_left = 0;

  sign_magnitude_fraction_divider_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_dividend           (in_dividend),
    .in_divisor            (in_divisor),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_quotient_whole    (out_quotient_whole),
    .out_quotient_fraction (out_quotient_fraction),
    .out_negative          (out_negative),
    .out_div_by_zero       (out_div_by_zero)
  );

  always #5 clk = ~clk;

  // restoring division of the magnitudes, whole bits then fraction bits
  function automatic quotient_t predict_quotient(input logic [DW-1:0] dividend,
                                                 input logic [DW-1:0] divisor);
    quotient_t     q;
    logic [DW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [63:0]   rem;
    logic [63:0]   den;
    logic [DW-1:0] whole;
    logic [FB-1:0] fraction;
    q = '0;
    num_mag = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
    den_mag = divisor[DW-1] ? (~divisor + 1'b1) : divisor;
    if (den_mag == '0) begin
      q.div_by_zero = 1'b1;
      return q;
    end
    rem = '0;
    den = {{(64-DW){1'b0}}, den_mag};
    whole = '0;
    fraction = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      rem = (rem << 1) | {63'b0, num_mag[i]};
      if (rem >= den) begin
        rem = rem - den;
        whole[i] = 1'b1;
      end
    end
    for (int i = 0; i < FB; i++) begin
      rem = rem << 1;
      fraction = fraction << 1;
      if (rem >= den) begin
        rem = rem - den;
        fraction[0] = 1'b1;
      end
    end
    // only the most negative dividend over a unit divisor overflows
    if (whole[DW-1]) begin
      whole = {1'b0, {(DW-1){1'b1}}};
      fraction = '1;
    end
    q.whole = whole[WW-1:0];
    q.fraction = fraction;
    q.negative = (num_mag != '0) && (dividend[DW-1] != divisor[DW-1]);
    return q;
  endfunction

  // offer one item, optionally after a gap, and wait until it is taken
  task automatic send_operands(input logic [DW-1:0] dividend, input logic [DW-1:0] divisor);
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dividend <= dividend;
    in_divisor <= divisor;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_quotients.insert(expected_quotients.size(), predict_quotient(dividend, divisor));
    items_sent++;
    if (divisor == '0) zero_divisor_count++;
  endtask

  function automatic logic [DW-1:0] random_operand();
    logic [DW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 64);
      1: v = $urandom_range(0, 4096);
      2: v = $urandom() >> $urandom_range(0, DW - 1);
      default: v = $urandom();
    endcase
    if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
    // replace the most negative value with the next value up
    if (v == MOST_NEG) v = MOST_NEG + 1'b1;
    return v;
  endfunction

  task automatic send_random_items(input int count);
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    for (int n = 0; n < count; n++) begin
      a = random_operand();
      b = random_operand();
      case ($urandom_range(0, 19))
        0: b = '0;
        1: a = '0;
        2: b = a;
        3: b = ~a + 1'b1;
        4, 5: begin
          // divisor above dividend, so only fraction bits come out
          a = $urandom_range(0, 1000);
          b = a + $urandom_range(1, 1000);
          if ($urandom_range(0, 1) == 1) b = ~b + 1'b1;
        end
        default: ;
      endcase
      if (b == MOST_NEG) b = MOST_NEG + 1'b1;
      send_operands(a, b);
    end
  endtask

  // receiver: counted long hold, else random stall bursts
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (recv_gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      burst_left = $urandom_range(1, 6) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    quotient_t exp_q;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_quotients.size() == 0) begin
        $error("result item with no prediction waiting");
        fail_count++;
      end else begin
        exp_q = expected_quotients.pop_front();
        results_checked++;
        if (out_quotient_whole !== exp_q.whole) begin
          $error("quotient_whole: expected %0d, got %0d", exp_q.whole, out_quotient_whole);
          fail_count++;
        end
        if (out_quotient_fraction !== exp_q.fraction) begin
          $error("quotient_fraction: expected %b, got %b", exp_q.fraction,
                 out_quotient_fraction);
          fail_count++;
        end
        if (out_negative !== exp_q.negative) begin
          $error("negative: expected %b, got %b", exp_q.negative, out_negative);
          fail_count++;
        end
        if (out_div_by_zero !== exp_q.div_by_zero) begin
          $error("div_by_zero: expected %b, got %b", exp_q.div_by_zero, out_div_by_zero);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_signs();
    send_operands(32'sd7, 32'sd2);
    send_operands(-32'sd7, 32'sd2);
    send_operands(32'sd7, -32'sd2);
    send_operands(-32'sd7, -32'sd2);
  endtask

  task automatic test_zero_operands();
    send_operands('0, 32'sd5);
    send_operands('0, -32'sd5);
    send_operands(32'sd5, '0);
    send_operands(-32'sd5, '0);
    send_operands('0, '0);
    send_operands(MOST_NEG, '0);
  endtask

  task automatic test_extremes();
    send_operands(MOST_POS, 32'sd1);
    send_operands(MOST_POS + 1'b1 + 1'b1, -32'sd1);
    // most negative dividend: exact magnitude, saturates over a unit divisor
    send_operands(MOST_NEG, 32'sd1);
    send_operands(MOST_NEG, -32'sd1);
    send_operands(MOST_NEG, 32'sd2);
    send_operands(32'sd1, MOST_POS);
    send_operands(32'sd1, MOST_NEG);
    send_operands(MOST_POS, MOST_POS);
    send_operands(MOST_POS, ~MOST_POS + 1'b1);
  endtask

  task automatic test_fractions();
    send_operands(32'sd1, 32'sd3);
    // remainder clears early, trailing fraction bits are zero
    send_operands(32'sd3, 32'sd4);
    send_operands(32'sd1, 32'sd32);
    send_operands(32'sd1, 32'sd33);
    send_operands(32'sd22, -32'sd7);
  endtask

  task automatic test_random_with_gaps();
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
    send_random_items(1200);
  endtask

  task automatic test_back_pressure();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    hold_req = 400;
    send_random_items(16);
  endtask

  task automatic test_random_full_rate();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    send_random_items(430);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_signs();
    test_zero_operands();
    test_extremes();
    test_fractions();
    test_random_with_gaps();
    test_back_pressure();
    test_random_full_rate();
    in_valid <= 1'b0;
    while (expected_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items divided and %0d results compared, %0d with a zero divisor;",
             items_sent, results_checked, zero_divisor_count);
    $display("signs, zero and extreme operands, fractions, random traffic and a long stall");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
